// ===== hw/rtl/irpr_pkg.sv =====
// ----------------------------------------------------------------------------
// irpr_pkg
// Shared codes and types for the impulse relay pulse/retry controller.
// ----------------------------------------------------------------------------
package irpr_pkg;

	localparam int unsigned TICK_W  = 16;
	localparam int unsigned RETRY_W = 3;
	localparam int unsigned REQ_W   = 2;
	localparam int unsigned PHASE_W = 2;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 16;

	// request types
	localparam logic [REQ_W-1:0] REQ_TICK     = 2'd0;
	localparam logic [REQ_W-1:0] REQ_SET      = 2'd1;
	localparam logic [REQ_W-1:0] REQ_FEEDBACK = 2'd2;

	// controller phases
	localparam logic [PHASE_W-1:0] PH_IDLE  = 2'd0;
	localparam logic [PHASE_W-1:0] PH_PULSE = 2'd1;
	localparam logic [PHASE_W-1:0] PH_WAIT  = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_PULSE_TICKS   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_TICKS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_RETRIES   = 2'd2;

	localparam logic [TICK_W-1:0]  PULSE_TICKS_RST   = 16'd200;
	localparam logic [TICK_W-1:0]  RELEASE_TICKS_RST = 16'd200;
	localparam logic [RETRY_W-1:0] MAX_RETRIES_RST   = 3'd3;
	localparam logic [RETRY_W-1:0] RETRY_SAT         = 3'd7;

	typedef struct packed {
		logic [TICK_W-1:0]  pulse_ticks;
		logic [TICK_W-1:0]  release_ticks;
		logic [RETRY_W-1:0] max_retries;
	} irpr_cfg_t;

	typedef struct packed {
		logic               drive_out;
		logic               relay_level;
		logic               level_known;
		logic               level_changed;
		logic [PHASE_W-1:0] phase;
		logic               gave_up;
	} irpr_result_t;

endpackage

// ===== hw/rtl/impulse_relay_pulse_retry_core.sv =====
// ----------------------------------------------------------------------------
// impulse_relay_pulse_retry_core
// Pulses an impulse relay until its feedback matches the requested level or the retry limit is reached.
// ----------------------------------------------------------------------------
// One request is taken per clock cycle; its result appears in the output
// register on the next cycle. The state update is a single pass through the
// control logic, and the only thing that holds the input back is a result
// still waiting in the output register while out_stall is high. Timing of
// the relay pulse and release is counted in tick requests, not clock cycles.
module impulse_relay_pulse_retry_core (
	input  logic                               clk,
	input  logic                               arst_n,
	// configuration
	input  logic                               wr_en,
	input  logic [irpr_pkg::CFG_IDX_W-1:0]     wr_index,
	input  logic [irpr_pkg::CFG_DATA_W-1:0]    wr_data,
	// request channel
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [irpr_pkg::REQ_W-1:0]         req_type,
	input  logic                               new_setpoint,
	input  logic                               feedback_level,
	input  logic                               feedback_present,
	// result channel
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic                               drive_out,
	output logic                               relay_level,
	output logic                               level_known,
	output logic                               level_changed,
	output logic [irpr_pkg::PHASE_W-1:0]       phase,
	output logic                               gave_up
);
	import irpr_pkg::*;

	irpr_cfg_t    cfg_q;
	irpr_result_t result;
	irpr_result_t result_q;
	logic         out_valid_q;
	logic         accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pulse_ticks   <= PULSE_TICKS_RST;
			cfg_q.release_ticks <= RELEASE_TICKS_RST;
			cfg_q.max_retries   <= MAX_RETRIES_RST;
		end else if (wr_en) begin
			case (wr_index)
				CFG_PULSE_TICKS:   cfg_q.pulse_ticks   <= wr_data[TICK_W-1:0];
				CFG_RELEASE_TICKS: cfg_q.release_ticks <= wr_data[TICK_W-1:0];
				CFG_MAX_RETRIES:   cfg_q.max_retries   <= wr_data[RETRY_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign in_stall = out_valid_q & out_stall;
	assign accept   = in_valid & ~in_stall;

	irpr_ctrl u_ctrl (
		.clk              (clk),
		.arst_n           (arst_n),
		.accept           (accept),
		.req_type         (req_type),
		.new_setpoint     (new_setpoint),
		.feedback_level   (feedback_level),
		.feedback_present (feedback_present),
		.cfg              (cfg_q),
		.result           (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			result_q <= result;
	end

	assign out_valid     = out_valid_q;
	assign drive_out     = result_q.drive_out;
	assign relay_level   = result_q.relay_level;
	assign level_known   = result_q.level_known;
	assign level_changed = result_q.level_changed;
	assign phase         = result_q.phase;
	assign gave_up       = result_q.gave_up;

	// the input is only held off by an unclaimed result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid_q)
		else $error("input stalled with empty output register");

	// every accepted request leaves a result behind
	a_accept_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> out_valid_q)
		else $error("accepted request produced no result");

	// a result stays put until it is taken
	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |=> (out_valid_q && $stable(result_q)))
		else $error("held result lost or changed");

endmodule

// ===== hw/rtl/irpr_ctrl.sv =====
// ----------------------------------------------------------------------------
// irpr_ctrl
// Relay control state and its per-request update; one request per cycle while accept is high.
// ----------------------------------------------------------------------------
module irpr_ctrl (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               accept,
	input  logic [irpr_pkg::REQ_W-1:0]         req_type,
	input  logic                               new_setpoint,
	input  logic                               feedback_level,
	input  logic                               feedback_present,
	input  irpr_pkg::irpr_cfg_t                cfg,
	output irpr_pkg::irpr_result_t             result
);
	import irpr_pkg::*;

	logic [PHASE_W-1:0] phase_q;
	logic [RETRY_W-1:0] retry_q;
	logic               setpoint_q;
	logic               level_q;
	logic               level_valid_q;
	logic               drive_q;
	logic [TICK_W-1:0]  timer_q;

	logic [PHASE_W-1:0] phase_d;
	logic [RETRY_W-1:0] retry_d;
	logic               setpoint_d;
	logic               level_d;
	logic               level_valid_d;
	logic               drive_d;
	logic [TICK_W-1:0]  timer_d;
	logic               changed_d;
	logic               gave_up_d;

	always_comb begin
		phase_d       = phase_q;
		retry_d       = retry_q;
		setpoint_d    = setpoint_q;
		level_d       = level_q;
		level_valid_d = level_valid_q;
		drive_d       = drive_q;
		timer_d       = timer_q;
		changed_d     = 1'b0;
		gave_up_d     = 1'b0;

		case (req_type)
			REQ_TICK: begin
				if (phase_q != PH_IDLE) begin
					if (timer_q inside {16'd0, 16'd1}) begin
						timer_d = '0;
						case (phase_q)
							PH_PULSE: begin
								drive_d = 1'b0;
								timer_d = cfg.release_ticks;
								phase_d = PH_WAIT;
								if (feedback_present) begin
									changed_d     = (level_q != feedback_level);
									level_d       = feedback_level;
									level_valid_d = 1'b1;
								end
							end
							PH_WAIT: begin
								if (feedback_present) begin
									changed_d     = (level_q != feedback_level);
									level_d       = feedback_level;
									level_valid_d = 1'b1;
								end
								if (level_d == setpoint_q) begin
									phase_d = PH_IDLE;
								end else if (retry_q >= cfg.max_retries) begin
									phase_d   = PH_IDLE;
									gave_up_d = 1'b1;
								end else begin
									// pulse again
									drive_d = 1'b1;
									timer_d = cfg.pulse_ticks;
									phase_d = PH_PULSE;
									if (retry_q != RETRY_SAT)
										retry_d = retry_q + RETRY_W'(1);
								end
							end
							default: begin
								phase_d = PH_IDLE;
							end
						endcase
					end else begin
						timer_d = timer_q - TICK_W'(1);
					end
				end
			end
			REQ_SET: begin
				setpoint_d = new_setpoint;
				retry_d    = '0;
				if (phase_q == PH_IDLE) begin
					if (feedback_present) begin
						changed_d     = (level_q != feedback_level);
						level_d       = feedback_level;
						level_valid_d = 1'b1;
					end
					if (new_setpoint != level_d) begin
						drive_d = 1'b1;
						timer_d = cfg.pulse_ticks;
						phase_d = PH_PULSE;
						retry_d = RETRY_W'(1);
					end
				end
			end
			REQ_FEEDBACK: begin
				if (phase_q == PH_IDLE && feedback_present) begin
					changed_d     = (level_q != feedback_level);
					level_d       = feedback_level;
					level_valid_d = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_IDLE;
			retry_q       <= '0;
			setpoint_q    <= 1'b0;
			level_q       <= 1'b0;
			level_valid_q <= 1'b0;
			drive_q       <= 1'b0;
			timer_q       <= '0;
		end else if (accept) begin
			phase_q       <= phase_d;
			retry_q       <= retry_d;
			setpoint_q    <= setpoint_d;
			level_q       <= level_d;
			level_valid_q <= level_valid_d;
			drive_q       <= drive_d;
			timer_q       <= timer_d;
		end
	end

	assign result.drive_out     = drive_d;
	assign result.relay_level   = level_d;
	assign result.level_known   = level_valid_d;
	assign result.level_changed = changed_d;
	assign result.phase         = phase_d;
	assign result.gave_up       = gave_up_d;

	// coil is driven exactly while a pulse is running
	a_drive_phase: assert property (@(posedge clk) disable iff (!arst_n)
		drive_q == (phase_q == PH_PULSE))
		else $error("drive level out of step with phase");

	// an idle controller has its timer run down
	a_idle_timer: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_IDLE) |-> (timer_q == '0))
		else $error("timer left loaded while idle");

	// giving up only ends a wait
	a_gave_up_wait: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && gave_up_d) |-> (phase_q == PH_WAIT && phase_d == PH_IDLE))
		else $error("give-up outside a wait check");

	// once known, the level never becomes unknown
	a_known_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		!$fell(level_valid_q))
		else $error("level validity lost");

endmodule
